// ----- rtl/core/h264rtp_pkg.sv -----
// Shared types and constants of the H.264 RTP packetizer.
`timescale 1ns / 1ps

package h264rtp_pkg;

    // Width of the NAL length field on the input.
    localparam int NAL_LENGTH_BITS = 20;
    // Width used to compare NAL lengths against 16-bit packet limits.
    localparam int CMP_BITS = (NAL_LENGTH_BITS > 16) ? NAL_LENGTH_BITS : 16;

    // Packet layout constants.
    localparam logic [15:0] MIN_PKT_LEN      = 16'd32;
    localparam logic [15:0] RTP_HDR_LEN      = 16'd12;
    localparam logic [15:0] TCP_RTP_HDR_LEN  = 16'd16;
    localparam logic [15:0] FU_HDR_LEN       = 16'd2;
    localparam logic [7:0]  TCP_MAGIC        = 8'h24;
    localparam logic [7:0]  TCP_CHANNEL      = 8'h00;
    localparam logic [7:0]  RTP_VERSION_BYTE = 8'h80;
    localparam logic [6:0]  RTP_PAYLOAD_TYPE = 7'd96;
    localparam logic [7:0]  FU_A_TYPE        = 8'd28;
    localparam logic [7:0]  NRI_MASK         = 8'h60;
    localparam logic [7:0]  NAL_TYPE_MASK    = 8'h1f;

    // Transaction queue between the classifier and the serializer.
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    // Byte slots of one job in the serializer, in output order.
    localparam int SLOT_BITS = 5;
    localparam logic [SLOT_BITS-1:0] SLOT_TCP      = 5'd0;
    localparam logic [SLOT_BITS-1:0] SLOT_RTP      = 5'd4;
    localparam logic [SLOT_BITS-1:0] SLOT_RTP_LAST = 5'd15;
    localparam logic [SLOT_BITS-1:0] SLOT_FU       = 5'd16;
    localparam logic [SLOT_BITS-1:0] SLOT_PAYLOAD  = 5'd18;
    localparam int NUM_SLOTS = 19;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_TCP_MODE    = 2'd0,
        CFG_TCP_MAX_LEN = 2'd1,
        CFG_UDP_MAX_LEN = 2'd2,
        CFG_SSRC        = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic        tcp_mode;
        logic [15:0] tcp_max_len;
        logic [15:0] udp_max_len;
        logic [31:0] stream_source_id;
    } cfg_t;

    typedef struct packed {
        logic [7:0]                 nal_byte;
        logic                       first_of_nal;
        logic [NAL_LENGTH_BITS-1:0] nal_length;
        logic [31:0]                timestamp;
    } nal_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_packet;
        logic       last_of_run;
    } pkt_item_t;

    // One classified input byte, ready for serialization.
    typedef struct packed {
        logic        has_header;
        logic        tcp;
        logic        fu;
        logic        marker;
        logic [15:0] rtp_len;
        logic [15:0] seq;
        logic [31:0] ts;
        logic [7:0]  fu_ind;
        logic [7:0]  fu_hdr;
        logic [7:0]  data;
        logic        eop;
    } job_t;

endpackage

// ----- rtl/core/h264rtp_front.sv -----
// Classifier: tracks NAL and fragment state and turns each byte into a job.
`timescale 1ns / 1ps

module h264rtp_front
    import h264rtp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      nal_valid,
    input  nal_item_t nal_data,
    output logic      nal_stall,
    input  logic      queue_full,
    output logic      push,
    output job_t      job
);

    logic [15:0]                seq_reg, seq_next;
    logic [NAL_LENGTH_BITS-1:0] remaining_reg, remaining_next;
    logic [15:0]                frag_pos_reg, frag_pos_next;
    logic [7:0]                 nal_hdr_reg, nal_hdr_next;
    logic                       fragmenting_reg, fragmenting_next;
    logic                       first_frag_reg, first_frag_next;
    logic [31:0]                ts_reg, ts_next;

    logic [15:0]                hdr_len, raw_lim, lim, fit_len, frag_len, fu_len, frag_pos_inc;
    logic [NAL_LENGTH_BITS-1:0] len0, remaining_dec;
    logic                       fits, frag_last, accept;

    assign nal_stall = queue_full;
    assign accept    = nal_valid && !queue_full;

    always_comb
    begin
        hdr_len      = cfg.tcp_mode ? TCP_RTP_HDR_LEN : RTP_HDR_LEN;
        raw_lim      = cfg.tcp_mode ? cfg.tcp_max_len : cfg.udp_max_len;
        lim          = (raw_lim < MIN_PKT_LEN) ? MIN_PKT_LEN : raw_lim;
        fit_len      = lim - hdr_len;
        frag_len     = fit_len - FU_HDR_LEN;
        len0         = (nal_data.nal_length == '0) ? NAL_LENGTH_BITS'(1) : nal_data.nal_length;
        fits         = CMP_BITS'(len0) <= CMP_BITS'(fit_len);
        frag_last    = CMP_BITS'(remaining_reg) <= CMP_BITS'(frag_len);
        fu_len       = (CMP_BITS'(remaining_reg) < CMP_BITS'(frag_len)) ?
                       16'(remaining_reg) : frag_len;
        remaining_dec = remaining_reg - NAL_LENGTH_BITS'(1);
        frag_pos_inc = frag_pos_reg + 16'd1;

        seq_next         = seq_reg;
        remaining_next   = remaining_reg;
        frag_pos_next    = frag_pos_reg;
        nal_hdr_next     = nal_hdr_reg;
        fragmenting_next = fragmenting_reg;
        first_frag_next  = first_frag_reg;
        ts_next          = ts_reg;

        push           = 1'b0;
        job.has_header = 1'b0;
        job.tcp        = cfg.tcp_mode;
        job.fu         = 1'b0;
        job.marker     = 1'b0;
        job.rtp_len    = '0;
        job.fu_ind     = (nal_hdr_reg & NRI_MASK) | FU_A_TYPE;
        job.fu_hdr     = '0;
        job.data       = nal_data.nal_byte;
        job.eop        = 1'b0;

        if (accept)
        begin
            if (nal_data.first_of_nal)
            begin
                ts_next        = nal_data.timestamp;
                nal_hdr_next   = nal_data.nal_byte;
                remaining_next = len0 - NAL_LENGTH_BITS'(1);
                frag_pos_next  = '0;
                if (fits)
                begin
                    fragmenting_next = 1'b0;
                    first_frag_next  = 1'b0;
                    seq_next         = seq_reg + 16'd1;
                    push             = 1'b1;
                    job.has_header   = 1'b1;
                    job.rtp_len      = 16'(len0) + RTP_HDR_LEN;
                    job.eop          = (len0 == NAL_LENGTH_BITS'(1));
                end
                else
                begin
                    // Oversized NAL: the header byte is held for the FU bytes.
                    fragmenting_next = 1'b1;
                    first_frag_next  = 1'b1;
                end
            end
            else if (remaining_reg == '0)
            begin
                // Stray byte outside any NAL is dropped.
            end
            else if (!fragmenting_reg)
            begin
                remaining_next = remaining_dec;
                push           = 1'b1;
                job.eop        = (remaining_dec == '0);
            end
            else
            begin
                if (frag_pos_reg == '0)
                begin
                    seq_next        = seq_reg + 16'd1;
                    job.has_header  = 1'b1;
                    job.fu          = 1'b1;
                    job.marker      = frag_last;
                    job.rtp_len     = fu_len + FU_HDR_LEN + RTP_HDR_LEN;
                    job.fu_hdr      = {first_frag_reg, frag_last, 1'b0, 5'b0} |
                                      (nal_hdr_reg & NAL_TYPE_MASK);
                    first_frag_next = 1'b0;
                end
                remaining_next = remaining_dec;
                push           = 1'b1;
                job.eop        = (remaining_dec == '0) || (frag_pos_inc >= frag_len);
                frag_pos_next  = job.eop ? 16'd0 : frag_pos_inc;
            end
        end

        job.seq = seq_next;
        job.ts  = ts_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg         <= '0;
            remaining_reg   <= '0;
            frag_pos_reg    <= '0;
            nal_hdr_reg     <= '0;
            fragmenting_reg <= 1'b0;
            first_frag_reg  <= 1'b0;
            ts_reg          <= '0;
        end
        else
        begin
            seq_reg         <= seq_next;
            remaining_reg   <= remaining_next;
            frag_pos_reg    <= frag_pos_next;
            nal_hdr_reg     <= nal_hdr_next;
            fragmenting_reg <= fragmenting_next;
            first_frag_reg  <= first_frag_next;
            ts_reg          <= ts_next;
        end
    end

endmodule

// ----- rtl/core/h264rtp_queue.sv -----
// Short job queue between the classifier and the serializer.
`timescale 1ns / 1ps

module h264rtp_queue
    import h264rtp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head
);

    job_t                      mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_PTR_BITS:0]   count_reg;

    assign full       = (count_reg == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_BITS'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_BITS'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (QUEUE_PTR_BITS + 1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (QUEUE_PTR_BITS + 1)'(1);
            end
        end
    end

endmodule

// ----- rtl/core/h264rtp_back.sv -----
// Serializer: emits each job's header and data bytes, one per unstalled cycle.
`timescale 1ns / 1ps

module h264rtp_back
    import h264rtp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] ssrc,
    input  logic        head_valid,
    input  job_t        head,
    output logic        pop,
    output logic        pkt_valid,
    input  logic        pkt_stall,
    output pkt_item_t   pkt_data
);

    logic [SLOT_BITS-1:0] pos_reg;
    logic                 started_reg;
    logic                 pkt_valid_reg;
    pkt_item_t            pkt_data_reg;

    logic [SLOT_BITS-1:0] start_pos, cur_pos, next_pos;
    logic [7:0]           slot_byte [NUM_SLOTS];
    logic                 advance, emit, at_payload;

    always_comb
    begin
        slot_byte[0]  = TCP_MAGIC;
        slot_byte[1]  = TCP_CHANNEL;
        slot_byte[2]  = head.rtp_len[15:8];
        slot_byte[3]  = head.rtp_len[7:0];
        slot_byte[4]  = RTP_VERSION_BYTE;
        slot_byte[5]  = {head.marker, RTP_PAYLOAD_TYPE};
        slot_byte[6]  = head.seq[15:8];
        slot_byte[7]  = head.seq[7:0];
        slot_byte[8]  = head.ts[31:24];
        slot_byte[9]  = head.ts[23:16];
        slot_byte[10] = head.ts[15:8];
        slot_byte[11] = head.ts[7:0];
        slot_byte[12] = ssrc[31:24];
        slot_byte[13] = ssrc[23:16];
        slot_byte[14] = ssrc[15:8];
        slot_byte[15] = ssrc[7:0];
        slot_byte[16] = head.fu_ind;
        slot_byte[17] = head.fu_hdr;
        slot_byte[18] = head.data;
    end

    always_comb
    begin
        if (!head.has_header)
        begin
            start_pos = SLOT_PAYLOAD;
        end
        else if (head.tcp)
        begin
            start_pos = SLOT_TCP;
        end
        else
        begin
            start_pos = SLOT_RTP;
        end
        cur_pos    = started_reg ? pos_reg : start_pos;
        at_payload = (cur_pos == SLOT_PAYLOAD);
        if (cur_pos == SLOT_RTP_LAST)
        begin
            next_pos = head.fu ? SLOT_FU : SLOT_PAYLOAD;
        end
        else
        begin
            next_pos = cur_pos + SLOT_BITS'(1);
        end
    end

    assign advance   = !pkt_valid_reg || !pkt_stall;
    assign emit      = advance && head_valid;
    assign pop       = emit && at_payload;
    assign pkt_valid = pkt_valid_reg;
    assign pkt_data  = pkt_data_reg;

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pkt_data_reg.out_byte      <= slot_byte[cur_pos];
            pkt_data_reg.end_of_packet <= at_payload && head.eop;
            pkt_data_reg.last_of_run   <= at_payload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            started_reg   <= 1'b0;
            pkt_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                pkt_valid_reg <= head_valid;
            end
            if (emit)
            begin
                started_reg <= !at_payload;
                pos_reg     <= next_pos;
            end
        end
    end

    // A job in progress keeps its queue entry until its data byte goes out.
    assert property (@(posedge clk) disable iff (!rst_n) started_reg |-> head_valid)
        else $error("serializer mid-job with an empty queue");

    // The slot counter never runs past the data byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |-> (pos_reg <= SLOT_PAYLOAD))
        else $error("serializer slot out of range");

    // A packet can only end on a data byte, which also closes its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pkt_valid && pkt_data.end_of_packet) |-> pkt_data.last_of_run)
        else $error("end of packet on a header byte");

    // Popping a job always coincides with emitting its data byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (pkt_valid && pkt_data.last_of_run))
        else $error("job popped without its data byte");

endmodule

// ----- rtl/core/h264_rtp_packetizer.sv -----
// Top level of the H.264 RTP packetizer: configuration registers and the three stages.
`timescale 1ns / 1ps

// H.264 RTP packetizer. NAL bytes enter one per transaction on the nal channel,
// start code removed, with the NAL length and timestamp taken on the first byte.
// A NAL that fits the packet limit leaves as one packet (optional 4-byte TCP
// interleave header, 12-byte RTP header, NAL bytes); a larger one leaves as FU-A
// fragments, each carrying the RTP header, FU indicator and FU header ahead of
// its first data byte, with the marker set on the last fragment. The input side
// takes one byte per cycle while the four-entry job queue has room. The output
// side emits one byte per cycle while pkt_stall is low; a data byte that opens a
// packet follows its 12-byte RTP header, plus 4 bytes for TCP and 2 for a
// fragment. Sustained throughput is one output byte per unstalled cycle, set by
// the byte-wide serializer. There is no clearing pass after reset. The block
// drops bytes that arrive outside a NAL, and a new NAL abandons an open one.
// Configuration writes are meant to happen while no transaction is in flight.

module h264_rtp_packetizer
    import h264rtp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        nal_valid,
    output logic        nal_stall,
    input  nal_item_t   nal_data,

    output logic        pkt_valid,
    input  logic        pkt_stall,
    output pkt_item_t   pkt_data
);

    cfg_t cfg_reg;
    logic queue_full;
    logic push;
    job_t push_job;
    logic pop;
    logic head_valid;
    job_t head;

    // Register file; all four registers are write-only from the port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tcp_mode         <= 1'b0;
            cfg_reg.tcp_max_len      <= 16'd1460;
            cfg_reg.udp_max_len      <= 16'd1400;
            cfg_reg.stream_source_id <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_TCP_MODE:    cfg_reg.tcp_mode         <= cfg_data[0];
                CFG_TCP_MAX_LEN: cfg_reg.tcp_max_len      <= cfg_data[15:0];
                CFG_UDP_MAX_LEN: cfg_reg.udp_max_len      <= cfg_data[15:0];
                CFG_SSRC:        cfg_reg.stream_source_id <= cfg_data;
                default:         cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // The front end decides packet boundaries and header contents per byte.
    h264rtp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .nal_valid  (nal_valid),
        .nal_data   (nal_data),
        .nal_stall  (nal_stall),
        .queue_full (queue_full),
        .push       (push),
        .job        (push_job)
    );

    // The queue lets the input keep flowing while header bursts go out.
    h264rtp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // The back end serializes each job into bytes behind an output register.
    h264rtp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .ssrc       (cfg_reg.stream_source_id),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .pkt_valid  (pkt_valid),
        .pkt_stall  (pkt_stall),
        .pkt_data   (pkt_data)
    );

endmodule
